[src/prcb_pkg.sv]
// Package: payload types, register indexes and the per-byte cross kernel.
package prcb_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int AddrW     = $clog2(MaxWidth);

    typedef enum logic [1:0] {
        CFG_BLUR_MODE    = 2'd0,
        CFG_ROUND_UP     = 2'd1,
        CFG_FRAME_WIDTH  = 2'd2,
        CFG_FRAME_HEIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] MODE_LIGHT = 2'd1;
    localparam logic [1:0] MODE_HEAVY = 2'd2;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [10:0] out_row;
        logic [10:0] out_col;
        logic        run_last;
        logic        frame_done;
    } t_out;

    function automatic logic [31:0] sh1(input logic [31:0] x);
        sh1 = (x & 32'hfefefeff) >> 1;
    endfunction
    function automatic logic [31:0] sh2(input logic [31:0] x);
        sh2 = (x & 32'hfcfcfcff) >> 2;
    endfunction
    function automatic logic [31:0] sh3(input logic [31:0] x);
        sh3 = (x & 32'hf8f8f8ff) >> 3;
    endfunction
    function automatic logic [31:0] sh4(input logic [31:0] x);
        sh4 = (x & 32'hf0f0f0ff) >> 4;
    endfunction

    function automatic logic [31:0] kern(
        input logic [1:0]  mode,
        input logic        rnd,
        input logic [31:0] c,
        input logic [31:0] l,
        input logic [31:0] r,
        input logic [31:0] u,
        input logic [31:0] d,
        input logic        hl,
        input logic        hr,
        input logic        hu,
        input logic        hd
    );
        logic [31:0] h1;
        logic [31:0] v1;
        logic [31:0] rm;
        logic        bh;
        logic        bv;
        h1 = hl ? l : r;
        v1 = hu ? u : d;
        bh = hl && hr;
        bv = hu && hd;
        rm = rnd ? 32'hffffffff : 32'h0;
        if (mode == MODE_LIGHT) begin
            if (!bh && !bv)
                kern = sh1(c) + sh2(c) + sh3(h1) + sh3(v1) + (32'h03030303 & rm);
            else if (bh && !bv)
                kern = sh1(c) + sh3(c) + sh3(l) + sh3(r) + sh3(v1) + (32'h04040404 & rm);
            else if (!bh)
                kern = sh1(c) + sh3(c) + sh3(h1) + sh3(u) + sh3(d) + (32'h00040404 & rm);
            else
                kern = sh1(c) + sh2(c) + sh4(l) + sh4(r) + sh4(u) + sh4(d)
                     + (32'h00050505 & rm);
        end else if (mode == MODE_HEAVY) begin
            if (!bh && !bv)
                kern = sh1(h1) + sh1(v1) + (32'h01010101 & rm);
            else if (bh && !bv)
                kern = sh2(l) + sh2(r) + sh1(v1) + (32'h02020202 & rm);
            else if (!bh)
                kern = sh1(h1) + sh2(u) + sh2(d) + (32'h00020202 & rm);
            else
                kern = sh2(l) + sh2(r) + sh2(u) + sh2(d) + (32'h00030303 & rm);
        end else begin
            if (!bh && !bv)
                kern = sh1(c) + sh2(h1) + sh2(v1) + (32'h02020202 & rm);
            else if (bh && !bv)
                kern = sh2(c) + sh2(l) + sh2(r) + sh2(v1) + (32'h03030303 & rm);
            else if (!bh)
                kern = sh2(c) + sh2(h1) + sh2(u) + sh2(d) + (32'h00030303 & rm);
            else
                kern = sh1(c) + sh3(l) + sh3(r) + sh3(u) + sh3(d) + (32'h00040404 & rm);
        end
    endfunction

endpackage

[src/packed_rgba_cross_blur.sv]
// Top level: streaming 3x3 cross blur of packed 32-bit pixels with two line stores.
// One pixel item is taken per clock unless o_stall is high. Both line stores
// share one 64-bit wide synchronous memory. A column is read as an item is
// taken and written back as it leaves stage 1, with forwarding when the same
// column comes back at once. Results pass from stage 1 to a four-entry output
// buffer and leave one per clock unless i_stall is high. An item on the last
// column of a line past the first yields two results, as does each item past
// column 0 on the last line (the frame's last pixel yields four). The input
// stalls while the buffer drains. Output trails input by one line and one pixel.
module packed_rgba_cross_blur (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  prcb_pkg::t_in      i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output prcb_pkg::t_out     o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [11:0]        i_cfg_data
);

    localparam int AW = prcb_pkg::AddrW;

    logic [1:0]  r_mode;
    logic        r_round;
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [10:0] r_row, n_row;
    logic [10:0] r_col, n_col;

    logic [63:0] mem [prcb_pkg::MaxWidth];
    logic [63:0] r_rd;
    logic        r_fwd;
    logic [63:0] r_fwd_data;
    logic [63:0] rd_eff;

    logic        r_s1_valid;
    logic [31:0] r_pix1;
    logic [10:0] r_r1;
    logic [10:0] r_c1;
    logic        r_has_up1, r_up21, r_cge11, r_cge21, r_lcol1, r_lrow1;

    logic [31:0] r_w1 [3];
    logic [31:0] r_w2 [3];
    logic [31:0] p2 [3];

    prcb_pkg::t_out r_res [4];
    prcb_pkg::t_out n_res [4];
    logic [2:0]  r_rem, n_cnt;
    logic [1:0]  r_idx;

    logic        accept, s1_fire, out_take, s2_free;
    logic [11:0] w_eff, h_eff;
    logic [11:0] c_t, r_t;
    logic [10:0] c0, r0;
    logic [11:0] cn, rn;

    always_comb begin
        w_eff = (r_width < 12'd2) ? 12'd2 :
                (r_width > 12'(prcb_pkg::MaxWidth)) ? 12'(prcb_pkg::MaxWidth) : r_width;
        h_eff = (r_height < 12'd2) ? 12'd2 :
                (r_height > 12'(prcb_pkg::MaxHeight)) ? 12'(prcb_pkg::MaxHeight) : r_height;
        c_t = i_data.frame_start ? 12'd0 : {1'b0, r_col};
        r_t = i_data.frame_start ? 12'd0 : {1'b0, r_row};
        if (c_t >= w_eff) begin
            c_t = 12'd0;
            r_t = r_t + 12'd1;
        end
        if (r_t >= h_eff) r_t = 12'd0;
        c0 = c_t[10:0];
        r0 = r_t[10:0];
        cn = c_t + 12'd1;
        rn = r_t;
        if (cn >= w_eff) begin
            cn = 12'd0;
            rn = r_t + 12'd1;
            if (rn >= h_eff) rn = 12'd0;
        end
        n_col = cn[10:0];
        n_row = rn[10:0];
    end

    assign out_take = o_valid && !i_stall;
    assign s2_free  = (r_rem == 3'd0) || (r_rem == 3'd1 && out_take);
    assign s1_fire  = r_s1_valid && s2_free;
    assign o_stall  = r_s1_valid && !s1_fire;
    assign accept   = i_valid && !o_stall;

    assign rd_eff = r_fwd ? r_fwd_data : r_rd;
    assign p2[0]  = rd_eff[63:32];
    assign p2[1]  = rd_eff[31:0];
    assign p2[2]  = r_pix1;

    // memory: read on accept, write back on stage-1 advance
    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= mem[c0[AW-1:0]];
        if (s1_fire) mem[r_c1[AW-1:0]] <= {rd_eff[31:0], r_pix1};
    end

    always_comb begin
        logic [31:0] k [4];
        logic        en [4];
        logic [10:0] rr [4];
        logic [10:0] cc [4];
        logic [2:0]  j;
        k[0] = prcb_pkg::kern(r_mode, r_round, r_w2[1], r_w1[1], p2[1], r_w2[0], r_w2[2],
                              r_cge21, 1'b1, r_up21, 1'b1);
        k[1] = prcb_pkg::kern(r_mode, r_round, p2[1], r_w2[1], 32'h0, p2[0], p2[2],
                              1'b1, 1'b0, r_up21, 1'b1);
        k[2] = prcb_pkg::kern(r_mode, r_round, r_w2[2], r_w1[2], p2[2], r_w2[1], 32'h0,
                              r_cge21, 1'b1, 1'b1, 1'b0);
        k[3] = prcb_pkg::kern(r_mode, r_round, p2[2], r_w2[2], 32'h0, p2[1], 32'h0,
                              1'b1, 1'b0, 1'b1, 1'b0);
        en[0] = r_has_up1 && r_cge11;
        en[1] = r_has_up1 && r_lcol1;
        en[2] = r_lrow1 && r_cge11;
        en[3] = r_lrow1 && r_lcol1;
        rr[0] = r_r1 - 11'd1;
        rr[1] = r_r1 - 11'd1;
        rr[2] = r_r1;
        rr[3] = r_r1;
        cc[0] = r_c1 - 11'd1;
        cc[1] = r_c1;
        cc[2] = r_c1 - 11'd1;
        cc[3] = r_c1;
        j = 3'd0;
        for (int i = 0; i < 4; i++) n_res[i] = '0;
        for (int i = 0; i < 4; i++) begin
            if (en[i]) begin
                n_res[j[1:0]].pixel_out  = k[i];
                n_res[j[1:0]].out_row    = rr[i];
                n_res[j[1:0]].out_col    = cc[i];
                n_res[j[1:0]].frame_done = (i == 3);
                j = j + 3'd1;
            end
        end
        if (j != 3'd0) n_res[2'(j - 3'd1)].run_last = 1'b1;
        n_cnt = j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 2'd0;
            r_round    <= 1'b0;
            r_width    <= 12'd640;
            r_height   <= 12'd480;
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_rem      <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prcb_pkg::CFG_BLUR_MODE:    r_mode   <= i_cfg_data[1:0];
                    prcb_pkg::CFG_ROUND_UP:     r_round  <= i_cfg_data[0];
                    prcb_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    prcb_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_fire && (c0 == r_c1);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (s1_fire) begin
                r_rem <= n_cnt;
                r_idx <= '0;
            end else if (out_take) begin
                r_rem <= r_rem - 3'd1;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1     <= i_data.pixel_in;
            r_r1       <= r0;
            r_c1       <= c0;
            r_has_up1  <= r0 >= 11'd1;
            r_up21     <= r0 >= 11'd2;
            r_cge11    <= c0 >= 11'd1;
            r_cge21    <= c0 >= 11'd2;
            r_lcol1    <= {1'b0, c0} == (w_eff - 12'd1);
            r_lrow1    <= {1'b0, r0} == (h_eff - 12'd1);
            r_fwd_data <= {rd_eff[31:0], r_pix1};
        end
        if (s1_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_w1[i] <= r_w2[i];
                r_w2[i] <= p2[i];
            end
            for (int i = 0; i < 4; i++) r_res[i] <= n_res[i];
        end
    end

    assign o_valid = r_rem != 3'd0;
    assign o_data  = r_res[r_idx];

    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag without stage-1 item");
    a_fire_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |-> (r_rem <= 3'd1))
        else $error("stage 1 advanced into full output buffer");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_done) |-> o_data.run_last)
        else $error("frame end result not last of its item");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem <= 3'd4) && ((r_rem == 3'd0) || (3'(r_idx) + r_rem <= 3'd4)))
        else $error("output buffer count out of range");

endmodule

[tb/tb_top.sv]
// Testbench for packed_rgba_cross_blur: self-checking pixel stream with its own blur predictor.
module tb_top;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    prcb_pkg::t_in     i_data;
    logic              o_valid;
    logic              i_stall;
    prcb_pkg::t_out    o_data;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [11:0]       i_cfg_data;

    packed_rgba_cross_blur dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [31:0] line_old [prcb_pkg::MaxWidth];
    logic [31:0] line_new [prcb_pkg::MaxWidth];
    logic [31:0] win [3][3];
    int unsigned cur_row, cur_col;
    logic [1:0]  m_mode;
    logic        m_round;
    logic [11:0] m_width, m_height;

    prcb_pkg::t_out blurred_q[$];
    int   errors;
    int   cycle_cnt;
    int   hold_cycles;
    bit   sender_quiet;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] shr(input logic [31:0] x, input int n);
        logic [7:0] bm;
        bm = 8'hff << n;
        return (x & {bm, bm, bm, 8'hff}) >> n;
    endfunction

    function automatic logic [31:0] cross_kernel(
        input logic [31:0] c, input logic [31:0] l, input logic [31:0] r,
        input logic [31:0] u, input logic [31:0] d,
        input bit hl, input bit hr, input bit hu, input bit hd);
        logic [31:0] h1, v1, rm;
        bit bh, bv;
        h1 = hl ? l : r;
        v1 = hu ? u : d;
        bh = hl && hr;
        bv = hu && hd;
        rm = m_round ? 32'hffffffff : 32'h0;
        if (m_mode == prcb_pkg::MODE_LIGHT) begin
            if (!bh && !bv) return shr(c,1) + shr(c,2) + shr(h1,3) + shr(v1,3)
                                   + (32'h03030303 & rm);
            if (bh && !bv) return shr(c,1) + shr(c,3) + shr(l,3) + shr(r,3) + shr(v1,3)
                                  + (32'h04040404 & rm);
            if (!bh) return shr(c,1) + shr(c,3) + shr(h1,3) + shr(u,3) + shr(d,3)
                            + (32'h00040404 & rm);
            return shr(c,1) + shr(c,2) + shr(l,4) + shr(r,4) + shr(u,4) + shr(d,4)
                   + (32'h00050505 & rm);
        end
        if (m_mode == prcb_pkg::MODE_HEAVY) begin
            if (!bh && !bv) return shr(h1,1) + shr(v1,1) + (32'h01010101 & rm);
            if (bh && !bv) return shr(l,2) + shr(r,2) + shr(v1,1) + (32'h02020202 & rm);
            if (!bh) return shr(h1,1) + shr(u,2) + shr(d,2) + (32'h00020202 & rm);
            return shr(l,2) + shr(r,2) + shr(u,2) + shr(d,2) + (32'h00030303 & rm);
        end
        if (!bh && !bv) return shr(c,1) + shr(h1,2) + shr(v1,2) + (32'h02020202 & rm);
        if (bh && !bv) return shr(c,2) + shr(l,2) + shr(r,2) + shr(v1,2)
                              + (32'h03030303 & rm);
        if (!bh) return shr(c,2) + shr(h1,2) + shr(u,2) + shr(d,2) + (32'h00030303 & rm);
        return shr(c,1) + shr(l,3) + shr(r,3) + shr(u,3) + shr(d,3) + (32'h00040404 & rm);
    endfunction

    function automatic int unsigned clamp_dim(input logic [11:0] v);
        if (v < 12'd2) return 2;
        if (v > 12'(prcb_pkg::MaxWidth)) return prcb_pkg::MaxWidth;
        return {20'd0, v};
    endfunction

    function automatic void push_blurred(input logic [31:0] pix, input int unsigned row,
                                         input int unsigned col, input bit done);
        prcb_pkg::t_out o;
        o.pixel_out  = pix;
        o.out_row    = row[10:0];
        o.out_col    = col[10:0];
        o.run_last   = 1'b0;
        o.frame_done = done;
        blurred_q.push_back(o);
    endfunction

    function automatic void blur_predict(input logic [31:0] pix, input bit fs);
        int unsigned w, h, r, c, n0;
        bit up;
        w = clamp_dim(m_width);
        h = clamp_dim(m_height);
        n0 = blurred_q.size();
        if (fs) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_old[c];
        win[1][2] = line_new[c];
        win[2][2] = pix;
        line_old[c] = line_new[c];
        line_new[c] = pix;
        if (r >= 1) begin
            up = (r - 1) >= 1;
            if (c >= 1)
                push_blurred(cross_kernel(win[1][1], win[1][0], win[1][2], win[0][1],
                             win[2][1], c - 1 >= 1, 1'b1, up, 1'b1), r - 1, c - 1, 1'b0);
            if (c == w - 1)
                push_blurred(cross_kernel(win[1][2], win[1][1], 32'h0, win[0][2], win[2][2],
                             1'b1, 1'b0, up, 1'b1), r - 1, c, 1'b0);
        end
        if (r == h - 1) begin
            if (c >= 1)
                push_blurred(cross_kernel(win[2][1], win[2][0], win[2][2], win[1][1], 32'h0,
                             c - 1 >= 1, 1'b1, 1'b1, 1'b0), r, c - 1, 1'b0);
            if (c == w - 1)
                push_blurred(cross_kernel(win[2][2], win[2][1], 32'h0, win[1][2], 32'h0,
                             1'b1, 1'b0, 1'b1, 1'b0), r, c, 1'b1);
        end
        if (blurred_q.size() > n0) blurred_q[blurred_q.size() - 1].run_last = 1'b1;
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (blurred_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, got %h", $time, o_data);
                errors++;
            end else begin
                prcb_pkg::t_out e;
                e = blurred_q.pop_front();
                if (o_data.pixel_out !== e.pixel_out)
                    $display("%0t: pixel_out expected %h got %h", $time, e.pixel_out,
                             o_data.pixel_out);
                if (o_data.out_row !== e.out_row)
                    $display("%0t: out_row expected %0d got %0d", $time, e.out_row,
                             o_data.out_row);
                if (o_data.out_col !== e.out_col)
                    $display("%0t: out_col expected %0d got %0d", $time, e.out_col,
                             o_data.out_col);
                if (o_data.run_last !== e.run_last)
                    $display("%0t: run_last expected %b got %b", $time, e.run_last,
                             o_data.run_last);
                if (o_data.frame_done !== e.frame_done)
                    $display("%0t: frame_done expected %b got %b", $time, e.frame_done,
                             o_data.frame_done);
                if (o_data !== e) errors++;
            end
        end
    end

    // receiver stall
    initial begin
        int run;
        i_stall = 1'b0;
        run = 0;
        cycle_cnt = 0;
        hold_cycles = 0;
        forever begin
            @(negedge i_clk);
            cycle_cnt++;
            if (hold_cycles > 0) begin
                i_stall = 1'b1;
                hold_cycles--;
            end else if (run > 0) begin
                i_stall = 1'b1;
                run--;
            end else if ((cycle_cnt / 300) % 3 == 0 || $urandom_range(0, 2) != 0) begin
                i_stall = 1'b0;
            end else begin
                i_stall = 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
            end
        end
    end

    task automatic send_pixel(input logic [31:0] pix, input bit fs);
        int gap;
        i_valid = 1'b1;
        i_data.pixel_in = pix;
        i_data.frame_start = fs;
        do @(posedge i_clk); while (o_stall);
        blur_predict(pix, fs);
        @(negedge i_clk);
        if (!sender_quiet && (cycle_cnt / 250) % 3 != 1 && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid = 1'b0;
        wait (blurred_q.size() == 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input prcb_pkg::t_cfg_idx idx, input logic [11:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            prcb_pkg::CFG_BLUR_MODE:    m_mode = val[1:0];
            prcb_pkg::CFG_ROUND_UP:     m_round = val[0];
            prcb_pkg::CFG_FRAME_WIDTH:  m_width = val;
            prcb_pkg::CFG_FRAME_HEIGHT: m_height = val;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [1:0] md, input bit rnd, input logic [11:0] w,
                           input logic [11:0] h);
        drain();
        write_reg(prcb_pkg::CFG_BLUR_MODE, {10'd0, md});
        write_reg(prcb_pkg::CFG_ROUND_UP, {11'd0, rnd});
        write_reg(prcb_pkg::CFG_FRAME_WIDTH, w);
        write_reg(prcb_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [31:0] rand_pixel;
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++) send_pixel(rand_pixel(), i == 0);
    endtask

    task automatic test_modes;
        for (int md = 0; md < 4; md++)
            for (int rnd = 0; rnd < 2; rnd++) begin
                set_all(md[1:0], rnd[0], (md == 0) ? 12'd0 : 12'd2, (md == 1) ? 12'd1 : 12'd2);
                send_pixel(32'hffffffff, 1'b1);
                send_pixel(32'h00000000, 1'b0);
                send_pixel(32'hffffffff, 1'b0);
                send_pixel(32'h80ff017f, 1'b0);
            end
        set_all(2'd0, 1'b1, 12'd3, 12'd3);
        send_frame(9);
    endtask

    task automatic test_wide_frame;
        set_all(2'd2, 1'b1, 12'd4095, 12'd2);
        send_frame(64);
        set_all(2'd1, 1'b0, 12'd2, 12'd4095);
        send_frame(40);
    endtask

    task automatic test_pressure;
        set_all(2'd3, 1'b1, 12'd4, 12'd4);
        sender_quiet = 1'b1;
        @(negedge i_clk);
        hold_cycles = 120;
        send_frame(16);
        send_frame(16);
        sender_quiet = 1'b0;
        drain();
        send_frame(16);
    endtask

    task automatic test_random;
        int sent, n, w, h;
        sent = 0;
        while (sent < 300) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(2, 8);
            h = $urandom_range(0, 5);
            set_all(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 12'(w), 12'(h));
            for (int f = 0; f < 2; f++) begin
                n = clamp_dim(12'(w)) * clamp_dim(12'(h));
                case ($urandom_range(0, 7))
                    0: n = $urandom_range(1, n);
                    1: n = n + $urandom_range(1, 2 * clamp_dim(12'(w)));
                    default: ;
                endcase
                for (int i = 0; i < n; i++)
                    send_pixel(rand_pixel(), i == 0 || $urandom_range(0, 150) == 0);
                sent += n;
            end
        end
    endtask

    initial begin
        errors = 0;
        sender_quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = prcb_pkg::CFG_BLUR_MODE;
        i_cfg_data = '0;
        m_mode = 2'd0;
        m_round = 1'b0;
        m_width = 12'd640;
        m_height = 12'd480;
        cur_row = 0;
        cur_col = 0;
        for (int i = 0; i < prcb_pkg::MaxWidth; i++) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) win[i][j] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_modes();
        test_pressure();
        test_random();
        test_wide_frame();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && blurred_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
